// File: hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Root kind codes shared by the quadratic root solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_DOUBLE = 2'd1;
   localparam logic [1:0] KIND_TWO    = 2'd2;
   localparam logic [1:0] KIND_DEGEN  = 2'd3;

endpackage

// File: hw/rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point.
//
// A request carries coef_a, coef_b and coef_c; each gives exactly one result
// with the exact discriminant, the root kind and both roots. One request is
// taken every clock cycle while req_stall is low. The block is a single
// pipeline: two discriminant stages, a set-up stage and one square-root stage
// per root bit (COEF_BITS+FRAC_BITS+1), a set-up stage and one divider stage
// per quotient bit (COEF_BITS+FRAC_BITS+3), and an output stage.
// The whole pipeline moves only when the output register is empty or its
// result is taken, so stalling rsp_stall freezes every stage in place and
// asserts req_stall; nothing is lost or repeated. Synchronous reset empties
// the pipeline; no request is taken during reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
   parameter int COEF_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COEF_BITS-1:0]         req_coef_a,
   input  logic signed [COEF_BITS-1:0]         req_coef_b,
   input  logic signed [COEF_BITS-1:0]         req_coef_c,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [2*COEF_BITS+1:0]       rsp_discriminant,
   output logic [1:0]                          rsp_root_kind,
   output logic signed [COEF_BITS+FRAC_BITS:0] rsp_root_low,
   output logic signed [COEF_BITS+FRAC_BITS:0] rsp_root_high
);

   logic                                advance;
   logic                                v1, v2;
   logic signed [COEF_BITS-1:0]         a1, b1, a2, b2;
   logic signed [2*COEF_BITS+1:0]       d1, d2;
   logic [COEF_BITS+FRAC_BITS:0]        r2;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || reset;

   qrs_disc #(.COEF_BITS(COEF_BITS)) u_disc (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid && !reset),
      .in_a(req_coef_a), .in_b(req_coef_b), .in_c(req_coef_c),
      .out_valid(v1), .out_a(a1), .out_b(b1), .out_disc(d1)
   );

   qrs_sqrt #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v1), .in_a(a1), .in_b(b1), .in_disc(d1),
      .out_valid(v2), .out_a(a2), .out_b(b2), .out_disc(d2), .out_root(r2)
   );

   qrs_div #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v2), .in_a(a2), .in_b(b2), .in_disc(d2), .in_root(r2),
      .out_valid(rsp_valid), .out_disc(rsp_discriminant), .out_kind(rsp_root_kind),
      .out_low(rsp_root_low), .out_high(rsp_root_high)
   );

endmodule

// File: hw/rtl/qrs_disc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_disc
// Two-stage discriminant pipeline: products, then the exact difference.
// ----------------------------------------------------------------------------
module qrs_disc #(
   parameter int COEF_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [COEF_BITS-1:0]   in_a,
   input  logic signed [COEF_BITS-1:0]   in_b,
   input  logic signed [COEF_BITS-1:0]   in_c,
   output logic                          out_valid,
   output logic signed [COEF_BITS-1:0]   out_a,
   output logic signed [COEF_BITS-1:0]   out_b,
   output logic signed [2*COEF_BITS+1:0] out_disc
);

   localparam int DW = 2 * COEF_BITS + 2;
   localparam int PW = 2 * COEF_BITS;

   logic                          v1_ff;
   logic signed [COEF_BITS-1:0]   a1_ff, b1_ff;
   logic signed [2*COEF_BITS-1:0] bb_ff, ac_ff;
   logic                          v2_ff;
   logic signed [COEF_BITS-1:0]   a2_ff, b2_ff;
   logic signed [DW-1:0]          d2_ff;
   logic signed [DW-1:0]          d2_in;

   assign d2_in = DW'(bb_ff) - (DW'(ac_ff) <<< 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         a1_ff <= in_a;
         b1_ff <= in_b;
         bb_ff <= PW'(in_b) * PW'(in_b);
         ac_ff <= PW'(in_a) * PW'(in_c);
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
         d2_ff <= d2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_a     = a2_ff;
   assign out_b     = b2_ff;
   assign out_disc  = d2_ff;

endmodule

// File: hw/rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root, one result bit per stage, of the
// discriminant scaled by two to the power of twice the fraction width.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
   parameter int COEF_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [COEF_BITS-1:0]   in_a,
   input  logic signed [COEF_BITS-1:0]   in_b,
   input  logic signed [2*COEF_BITS+1:0] in_disc,
   output logic                          out_valid,
   output logic signed [COEF_BITS-1:0]   out_a,
   output logic signed [COEF_BITS-1:0]   out_b,
   output logic signed [2*COEF_BITS+1:0] out_disc,
   output logic [COEF_BITS+FRAC_BITS:0]  out_root
);

   localparam int DW = 2 * COEF_BITS + 2;
   localparam int RB = COEF_BITS + FRAC_BITS + 1;
   localparam int XW = 2 * RB;
   localparam int MW = RB + 2;

   logic                          v_ff [RB+1];
   logic signed [COEF_BITS-1:0]   a_ff [RB+1];
   logic signed [COEF_BITS-1:0]   b_ff [RB+1];
   logic signed [DW-1:0]          d_ff [RB+1];
   logic [XW-1:0]                 x_ff [RB+1];
   logic [MW-1:0]                 m_ff [RB+1];
   logic [RB-1:0]                 q_ff [RB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
      if (advance) begin
         a_ff[0] <= in_a;
         b_ff[0] <= in_b;
         d_ff[0] <= in_disc;
         x_ff[0] <= in_disc[DW-1] ? '0 : (XW'(in_disc[DW-2:0]) << (2 * FRAC_BITS));
         m_ff[0] <= '0;
         q_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < RB; g++) begin : g_step
      logic [MW-1:0] rem_w, trial_w;
      logic          fit_w;
      assign rem_w   = {m_ff[g][MW-3:0], x_ff[g][XW-1 -: 2]};
      assign trial_w = {q_ff[g], 2'b01};
      assign fit_w   = rem_w >= trial_w;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (advance) begin
            v_ff[g+1] <= v_ff[g];
         end
         if (advance) begin
            a_ff[g+1] <= a_ff[g];
            b_ff[g+1] <= b_ff[g];
            d_ff[g+1] <= d_ff[g];
            x_ff[g+1] <= x_ff[g] << 2;
            m_ff[g+1] <= fit_w ? rem_w - trial_w : rem_w;
            q_ff[g+1] <= {q_ff[g][RB-2:0], fit_w};
         end
      end
   end

   assign out_valid = v_ff[RB];
   assign out_a     = a_ff[RB];
   assign out_b     = b_ff[RB];
   assign out_disc  = d_ff[RB];
   assign out_root  = q_ff[RB];

endmodule

// File: hw/rtl/qrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Classifies the request, forms both numerators and divides them by 2a in two
// parallel pipelined restoring dividers, one quotient bit per stage, then
// fixes signs and saturates the result.
// ----------------------------------------------------------------------------
module qrs_div #(
   parameter int COEF_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [COEF_BITS-1:0]   in_a,
   input  logic signed [COEF_BITS-1:0]   in_b,
   input  logic signed [2*COEF_BITS+1:0] in_disc,
   input  logic [COEF_BITS+FRAC_BITS:0]  in_root,
   output logic                          out_valid,
   output logic signed [2*COEF_BITS+1:0] out_disc,
   output logic [1:0]                    out_kind,
   output logic signed [COEF_BITS+FRAC_BITS:0] out_low,
   output logic signed [COEF_BITS+FRAC_BITS:0] out_high
);

   localparam int DW = 2 * COEF_BITS + 2;
   localparam int RB = COEF_BITS + FRAC_BITS + 1;
   localparam int NW = RB + 2;
   localparam int QW = NW;
   localparam int EW = COEF_BITS + 1;
   localparam int RW = EW + 1;

   logic signed [NW-1:0] nb_w, nlo_w, nhi_w;
   logic [1:0]           kind_w;
   logic                 sz_w;

   assign nb_w  = -(NW'(in_b) <<< FRAC_BITS);
   assign nlo_w = nb_w - NW'({1'b0, in_root});
   assign nhi_w = nb_w + NW'({1'b0, in_root});
   assign sz_w  = (in_a == '0) || in_disc[DW-1];

   always_comb begin
      if (in_a == '0) begin
         kind_w = qrs_pkg::KIND_DEGEN;
      end else if (in_disc[DW-1]) begin
         kind_w = qrs_pkg::KIND_NONE;
      end else if (in_disc == '0) begin
         kind_w = qrs_pkg::KIND_DOUBLE;
      end else begin
         kind_w = qrs_pkg::KIND_TWO;
      end
   end

   logic              v_ff  [QW+1];
   logic [DW-1:0]     d_ff  [QW+1];
   logic [1:0]        k_ff  [QW+1];
   logic              z_ff  [QW+1];
   logic [EW-1:0]     den_ff[QW+1];
   logic              sl_ff [QW+1];
   logic              sh_ff [QW+1];
   logic [NW-1:0]     xl_ff [QW+1];
   logic [NW-1:0]     xh_ff [QW+1];
   logic [RW-1:0]     rl_ff [QW+1];
   logic [RW-1:0]     rh_ff [QW+1];

   logic signed [EW-1:0] den_s;
   assign den_s = EW'(in_a) <<< 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
      if (advance) begin
         d_ff[0]   <= in_disc;
         k_ff[0]   <= kind_w;
         z_ff[0]   <= sz_w;
         den_ff[0] <= den_s[EW-1] ? -den_s : den_s;
         sl_ff[0]  <= nlo_w[NW-1] ^ den_s[EW-1];
         sh_ff[0]  <= nhi_w[NW-1] ^ den_s[EW-1];
         xl_ff[0]  <= nlo_w[NW-1] ? -nlo_w : nlo_w;
         xh_ff[0]  <= nhi_w[NW-1] ? -nhi_w : nhi_w;
         rl_ff[0]  <= '0;
         rh_ff[0]  <= '0;
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_step
      logic [RW-1:0] tl_w, th_w;
      logic          fl_w, fh_w;
      assign tl_w = {rl_ff[g][RW-2:0], xl_ff[g][NW-1]};
      assign th_w = {rh_ff[g][RW-2:0], xh_ff[g][NW-1]};
      assign fl_w = tl_w >= RW'(den_ff[g]);
      assign fh_w = th_w >= RW'(den_ff[g]);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (advance) begin
            v_ff[g+1] <= v_ff[g];
         end
         if (advance) begin
            d_ff[g+1]   <= d_ff[g];
            k_ff[g+1]   <= k_ff[g];
            z_ff[g+1]   <= z_ff[g];
            den_ff[g+1] <= den_ff[g];
            sl_ff[g+1]  <= sl_ff[g];
            sh_ff[g+1]  <= sh_ff[g];
            rl_ff[g+1]  <= fl_w ? tl_w - RW'(den_ff[g]) : tl_w;
            rh_ff[g+1]  <= fh_w ? th_w - RW'(den_ff[g]) : th_w;
            xl_ff[g+1]  <= {xl_ff[g][NW-2:0], fl_w};
            xh_ff[g+1]  <= {xh_ff[g][NW-2:0], fh_w};
         end
      end
   end

   function automatic logic [RB-1:0] sat_root(input logic [NW-1:0] q, input logic neg);
      logic [NW:0] mag;
      logic [NW:0] lim;
      mag = {1'b0, q};
      lim = (NW+1)'({1'b1, {(RB-1){1'b0}}});
      if (neg) begin
         sat_root = (mag >= lim) ? RB'(lim) : RB'(-mag);
      end else begin
         sat_root = (mag >= lim) ? RB'(lim - 1'b1) : RB'(mag);
      end
   endfunction

   logic              vo_ff;
   logic [DW-1:0]     do_ff;
   logic [1:0]        ko_ff;
   logic [RB-1:0]     lo_ff, hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (advance) begin
         vo_ff <= v_ff[QW];
      end
      if (advance) begin
         do_ff <= d_ff[QW];
         ko_ff <= k_ff[QW];
         lo_ff <= z_ff[QW] ? '0 : sat_root(xl_ff[QW], sl_ff[QW]);
         hi_ff <= z_ff[QW] ? '0 : sat_root(xh_ff[QW], sh_ff[QW]);
      end
   end

   assign out_valid = vo_ff;
   assign out_disc  = do_ff;
   assign out_kind  = ko_ff;
   assign out_low   = lo_ff;
   assign out_high  = hi_ff;

endmodule

// File: tb/quadratic_root_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Self-checking testbench for the quadratic root solver.
//
// A table of directed coefficient triples is followed by random triples. Every
// request is predicted in the testbench and each result is compared field by
// field with the oldest prediction. Sender gaps and receiver stalls are varied
// over several phases, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;

   localparam int CB = 16;
   localparam int FB = 16;
   localparam int DW = 2*CB+2;
   localparam int RW = CB+FB+1;
   localparam int LATENCY = 2*CB+2*FB+9;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic signed [DW-1:0] disc;
      logic [1:0]           kind;
      logic signed [RW-1:0] lo;
      logic signed [RW-1:0] hi;
   } roots_type;

   typedef struct {
      logic signed [CB-1:0] a, b, c;
      logic                 typed;
      roots_type            want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_coef_a = '0, req_coef_b = '0, req_coef_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_discriminant;
   logic [1:0] rsp_root_kind;
   logic signed [RW-1:0] rsp_root_low, rsp_root_high;

   roots_type pending_roots[$];
   int errors = 0;
   int received = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off = 0;
   int kind_seen[4] = '{0, 0, 0, 0};

   quadratic_root_solver #(.COEF_BITS(CB), .FRAC_BITS(FB)) uut (
      .clock, .reset, .req_valid, .req_stall, .req_coef_a, .req_coef_b,
      .req_coef_c, .rsp_valid, .rsp_stall, .rsp_discriminant, .rsp_root_kind,
      .rsp_root_low, .rsp_root_high
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint scaled_sqrt(longint d);
      longint lo_b, hi_b, mid;
      logic [127:0] sq, rad;
      lo_b = 0;
      hi_b = 64'sd1 <<< 34;
      rad = 128'(d) << (2*FB);
      while (lo_b < hi_b) begin
         mid = (lo_b + hi_b + 1) / 2;
         sq = 128'(mid) * 128'(mid);
         if (sq <= rad) lo_b = mid;
         else hi_b = mid - 1;
      end
      return lo_b;
   endfunction

   function automatic longint clamp_root(longint v);
      longint top;
      top = (64'sd1 <<< (RW-1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
   endfunction

   function automatic roots_type solve_quadratic(logic signed [CB-1:0] a,
                                                 logic signed [CB-1:0] b,
                                                 logic signed [CB-1:0] c);
      roots_type r;
      longint la, lb, lc, d, s, nb, den;
      la = a; lb = b; lc = c;
      d = lb*lb - 4*la*lc;
      r.disc = d[DW-1:0];
      r.lo = '0;
      r.hi = '0;
      if (la == 0) r.kind = qrs_pkg::KIND_DEGEN;
      else if (d < 0) r.kind = qrs_pkg::KIND_NONE;
      else begin
         s = scaled_sqrt(d);
         nb = -lb * (64'sd1 <<< FB);
         den = 2*la;
         r.kind = (d > 0) ? qrs_pkg::KIND_TWO : qrs_pkg::KIND_DOUBLE;
         r.lo = RW'(clamp_root((nb - s) / den));
         r.hi = RW'(clamp_root((nb + s) / den));
      end
      return r;
   endfunction

   task automatic send_triple(logic signed [CB-1:0] a, logic signed [CB-1:0] b,
                              logic signed [CB-1:0] c, logic typed, roots_type want);
      roots_type r;
      r = typed ? want : solve_quadratic(a, b, c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_roots.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_roots.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [CB-1:0] pick_coef();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         1: return CB'($urandom_range(8) - 4);
         2: return CB'($urandom_range(200) - 100);
         default: return CB'($urandom);
      endcase
   endfunction

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      roots_type exp_r;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         received <= received + 1;
         if (pending_roots.size() == 0) begin
            $error("result with no request outstanding");
            errors = errors + 1;
         end else begin
            exp_r = pending_roots.pop_front();
            kind_seen[exp_r.kind] <= kind_seen[exp_r.kind] + 1;
            if (rsp_discriminant !== exp_r.disc) begin
               $error("discriminant: expected %0d, got %0d", exp_r.disc,
                      rsp_discriminant);
               errors = errors + 1;
            end
            if (rsp_root_kind !== exp_r.kind) begin
               $error("root_kind: expected %0d, got %0d", exp_r.kind, rsp_root_kind);
               errors = errors + 1;
            end
            if (rsp_root_low !== exp_r.lo) begin
               $error("root_low: expected %0d, got %0d", exp_r.lo, rsp_root_low);
               errors = errors + 1;
            end
            if (rsp_root_high !== exp_r.hi) begin
               $error("root_high: expected %0d, got %0d", exp_r.hi, rsp_root_high);
               errors = errors + 1;
            end
         end
      end
   end

   initial begin
      row_type rows[$];
      roots_type w;
      int phase_idle[5] = '{0, 80, 0, 38, 20};
      int phase_stall[5] = '{0, 0, 80, 38, 20};
      // Typed rows: a is zero gives b squared; a equation with no real roots;
      // a double root at x = 1 (x^2 - 2x + 1).
      w = '{disc: 34'sd1073741824, kind: qrs_pkg::KIND_DEGEN, lo: '0, hi: '0};
      rows.push_back('{16'sd0, 16'sh8000, 16'sd5, 1'b1, w});
      w = '{disc: -34'sd4, kind: qrs_pkg::KIND_NONE, lo: '0, hi: '0};
      rows.push_back('{16'sd1, 16'sd0, 16'sd1, 1'b1, w});
      w = '{disc: 34'sd0, kind: qrs_pkg::KIND_DOUBLE, lo: 33'sd65536, hi: 33'sd65536};
      rows.push_back('{16'sd1, -16'sd2, 16'sd1, 1'b1, w});
      rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b0, w});
      rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, w});
      rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, w});
      rows.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, w});
      rows.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, w});
      rows.push_back('{16'sd1, 16'sh8000, 16'sh8000, 1'b0, w});
      rows.push_back('{16'sh8000, 16'sd0, 16'sh7fff, 1'b0, w});
      rows.push_back('{-16'sd1, 16'sd3, 16'sd4, 1'b0, w});
      rows.push_back('{16'sd1, 16'sd0, -16'sd2, 1'b0, w});
      rows.push_back('{16'sd3, 16'sd7, -16'sd11, 1'b0, w});
      rows.push_back('{-16'sd2, -16'sd4, -16'sd2, 1'b0, w});
      rows.push_back('{16'sh5555, 16'shaaaa, 16'sd1, 1'b0, w});
      rows.push_back('{16'sd1, 16'sh7fff, 16'sd0, 1'b0, w});
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_triple(rows[i].a, rows[i].b, rows[i].c,
                                    rows[i].typed, rows[i].want);
      drain();
      for (int p = 0; p < 5; p++) begin
         send_idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         if (p == 4) hold_off = 3*LATENCY;
         for (int n = 0; n < 380; n++) begin
            logic signed [CB-1:0] a, b, c;
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
            if ($urandom_range(9) == 0) begin
               // Perfect squares k(x - m)^2 give double roots when k is nonzero and k*m^2 fits in c.
               a = CB'($urandom_range(200) - 100);
               b = CB'(-2 * a * ($urandom_range(40) - 20));
               c = CB'((b * b) / (4 * (a == 0 ? 1 : a)));
            end
            send_triple(a, b, c, 1'b0, w);
         end
         drain();
      end
      stall_pct = 0;
      repeat (LATENCY + 10) @(negedge clock);
      $display("Sent %0d requests, received %0d results: none %0d, double %0d,",
               16 + 5*380, received, kind_seen[qrs_pkg::KIND_NONE],
               kind_seen[qrs_pkg::KIND_DOUBLE]);
      $display("two roots %0d, degenerate %0d, across five idling phases.",
               kind_seen[qrs_pkg::KIND_TWO], kind_seen[qrs_pkg::KIND_DEGEN]);
      if (errors == 0 && pending_roots.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
